>>> sv/chained_hash_dictionary_core_macros.svh
// Assertion macros for the hash dictionary checker.
// Included by chd_checker.sv; no other dependencies.
`ifndef CHAINED_HASH_DICTIONARY_CORE_MACROS_SVH
`define CHAINED_HASH_DICTIONARY_CORE_MACROS_SVH
// implication checked on every clock, disabled in reset
`define CHD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> sv/chd_pkg.sv
// Package for the chained hash dictionary: status and kind codes, FSM states.
// No dependencies.
package chd_pkg;
	localparam logic [1:0] KIND_FIND    = 2'd0;
	localparam logic [1:0] KIND_ADD     = 2'd1;
	localparam logic [1:0] KIND_REPLACE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// 2**7 - 1: the hash is reduced by folding 7-bit chunks
	localparam int BUCKETS = 127;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_HEAD,
		S_WALK,
		S_CMP,
		S_DONE
	} state_t;
endpackage

>>> sv/chd_stream_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface chd_stream_if #(parameter int W = 8) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/chained_hash_dictionary_core.sv
// Hash dictionary with separate chaining (sdbm hash, chains in block memory).
// Input channel in_ch carries {kind, key, value}; out_ch carries {status, value_out}.
// One operation at a time: the block takes an item, hashes the key one byte a
// cycle (at most KEY_BYTES bytes), reduces the hash mod BUCKETS by folding 7-bit
// chunks and waits for the bucket head read, then walks the chain, for each
// entry a memory read and a compare. Replace and unused kinds skip the walk.
// The result sits in an output register until taken; a stalled receiver holds
// the block in its done state and no new item is accepted.
// Reset clears the bucket heads through valid bits and clears the fill count;
// the entry memories are not cleared (chains only reach written entries).
// Payload bit order, high to low: in = {kind[1:0], key[63:0], value[31:0]},
// out = {status[1:0], value_out[VALUE_WIDTH-1:0]} (value_out zero-extended to 32).
module chained_hash_dictionary_core #(
	parameter int CAPACITY    = 256,
	parameter int KEY_BYTES   = 8,
	parameter int VALUE_WIDTH = 32
) (
	input logic           clk,
	input logic           arst_n,
	chd_stream_if.sink    in_ch,
	chd_stream_if.source  out_ch
);
	import chd_pkg::*;

	localparam int EW = $clog2(CAPACITY + 1);   // entry number plus one
	localparam int EA = $clog2(CAPACITY);
	localparam int BW = $clog2(BUCKETS);
	localparam int BB = (BW < 1) ? 1 : BW;

	state_t state_q, state_n;

	logic [1:0]             kind_q;
	logic [63:0]            key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [63:0]            hash_q;
	logic [3:0]             byte_q;
	logic [1:0]             bit_q;
	logic [BW:0]            rem_q;
	logic [EW-1:0]          ptr_q;
	logic [EW-1:0]          used_q;
	logic [1:0]             status_q;
	logic [VALUE_WIDTH-1:0] vout_q;
	logic                   ovalid_q;

	// memories
	logic [EW-1:0]          head_mem [BUCKETS];
	logic [BUCKETS-1:0]     head_vld_q;
	logic [63:0]            key_mem  [CAPACITY];
	logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];
	logic [EW-1:0]          link_mem [CAPACITY];
	logic [EW-1:0]          head_rd_q;
	logic                   head_rv_q;
	logic [63:0]            key_rd_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;
	logic [EW-1:0]          link_rd_q;

	logic [BB-1:0] bkt;
	logic [EA-1:0] ptr_idx, used_idx;
	logic [7:0]    cur_byte;
	logic          name_end;
	logic [10:0]   fold_sum;
	logic [7:0]    fold_lo;
	logic          do_insert;
	logic          full;

	assign bkt      = BB'(rem_q);
	assign ptr_idx  = EA'(ptr_q - EW'(1));
	assign used_idx = EA'(used_q);
	assign cur_byte = key_q[byte_q[2:0]*8 +: 8];
	assign name_end = (32'(byte_q) >= KEY_BYTES) || (byte_q[3]) || (cur_byte == 8'd0);
	assign full     = (32'(used_q) >= CAPACITY);

	// 2**7 = 1 mod 127: the sum of the 7-bit chunks keeps the remainder
	always_comb begin
		fold_sum = 11'(hash_q[63]);
		for (int i = 0; i < 9; i++)
			fold_sum = fold_sum + 11'(hash_q[7*i +: 7]);
	end
	assign fold_lo = 8'(hash_q[6:0]) + 8'(hash_q[10:7]);

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = {status_q, 32'(vout_q)};

	always_comb begin
		state_n   = state_q;
		do_insert = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_ch.valid) state_n = S_HASH;
			S_HASH: if (name_end) state_n = S_MOD;
			S_MOD:  if (bit_q == 2'd2) state_n = S_HEAD;
			S_HEAD: begin
				if (kind_q == KIND_REPLACE) begin
					do_insert = !full;
					state_n   = S_DONE;
				end else if (kind_q != KIND_FIND && kind_q != KIND_ADD) begin
					state_n = S_DONE;
				end else begin
					state_n = S_WALK;
				end
			end
			S_WALK: begin
				if (ptr_q == '0) begin
					do_insert = (kind_q == KIND_ADD) && !full;
					state_n   = S_DONE;
				end else begin
					state_n = S_CMP;
				end
			end
			S_CMP:  state_n = (key_rd_q == key_q) ? S_DONE : S_WALK;
			S_DONE: if (out_ch.ready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_n;
	end

	// entry and head memories
	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[bkt];
		key_rd_q  <= key_mem[ptr_idx];
		val_rd_q  <= val_mem[ptr_idx];
		link_rd_q <= link_mem[ptr_idx];
		if (do_insert) begin
			key_mem[used_idx]  <= key_q;
			val_mem[used_idx]  <= val_q;
			link_mem[used_idx] <= head_rv_q ? head_rd_q : '0;
			head_mem[bkt]      <= used_q + EW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			used_q     <= '0;
			ovalid_q   <= 1'b0;
			head_rv_q  <= 1'b0;
		end else begin
			head_rv_q <= head_vld_q[bkt];
			if (do_insert) begin
				head_vld_q[bkt] <= 1'b1;
				used_q          <= used_q + EW'(1);
			end
			if (state_q != S_DONE && state_n == S_DONE) ovalid_q <= 1'b1;
			else if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				kind_q <= in_ch.data[97:96];
				key_q  <= in_ch.data[95:32];
				val_q  <= VALUE_WIDTH'(in_ch.data[31:0]);
				hash_q <= '0;
				byte_q <= '0;
				bit_q  <= '0;
				rem_q  <= '0;
			end
			S_HASH: begin
				if (name_end) begin
					// clear bytes past the end of the name
					for (int i = 0; i < 8; i++)
						if (i >= 32'(byte_q)) key_q[i*8 +: 8] <= 8'd0;
				end else begin
					hash_q <= 64'(cur_byte) + (hash_q << 6) + (hash_q << 16) - hash_q;
					byte_q <= byte_q + 4'd1;
				end
			end
			S_MOD: begin
				// chunk sum, then fold and correct, then a step that waits on the head read
				bit_q <= bit_q + 2'd1;
				if (bit_q == 2'd0) hash_q <= 64'(fold_sum);
				else if (bit_q == 2'd1) begin
					if (fold_lo >= 8'(BUCKETS)) rem_q <= (BW+1)'(fold_lo - 8'(BUCKETS));
					else rem_q <= (BW+1)'(fold_lo);
				end
			end
			S_HEAD: begin
				ptr_q    <= head_rv_q ? head_rd_q : '0;
				status_q <= ST_MISS;
				vout_q   <= '0;
				if (kind_q == KIND_REPLACE) status_q <= full ? ST_FULL : ST_OK;
			end
			S_WALK: begin
				if (ptr_q == '0 && kind_q == KIND_ADD) status_q <= full ? ST_FULL : ST_OK;
			end
			S_CMP: begin
				if (key_rd_q == key_q) begin
					if (kind_q == KIND_FIND) begin
						status_q <= ST_OK;
						vout_q   <= val_rd_q;
					end
				end else begin
					ptr_q <= link_rd_q;
				end
			end
			default: ;
		endcase
	end
endmodule

>>> sv/chd_checker.sv
// Port-level checker for chained_hash_dictionary_core, bound into that module.
// Depends on chd_pkg and chained_hash_dictionary_core_macros.svh.
`include "chained_hash_dictionary_core_macros.svh"
module chd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [33:0] out_data
);
	import chd_pkg::*;
	`CHD_ASSERT_IMP(a_one_at_a_time, clk, arst_n, out_valid, !in_ready, "input taken while result pending")
	`CHD_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready, "ready after transfer")
	`CHD_ASSERT_IMP(a_vout_zero, clk, arst_n, out_valid && out_data[33:32] != ST_OK, out_data[31:0] == 32'd0, "value_out nonzero on miss")
	`CHD_ASSERT_IMP(a_status_code, clk, arst_n, out_valid, out_data[33:32] != 2'd3, "bad status code")
endmodule

bind chained_hash_dictionary_core chd_checker u_chd_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for chained_hash_dictionary_core.
// Depends on chd_pkg and chd_stream_if; predicts find/add/replace results
// with its own copy of the chained table and compares every out_ch transfer.
`timescale 1ns / 1ps
module tb_top;
	import chd_pkg::*;

	localparam int CAP = 256;
	localparam int NBKT = 127;
	localparam int LIMIT = 10000000;

	logic clk;
	logic arst_n;

	chd_stream_if #(.W(98)) in_ch ();
	chd_stream_if #(.W(34)) out_ch ();

	chained_hash_dictionary_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] key;
		logic [31:0] value;
	} op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
	} res_t;

	// predictor state
	int unsigned   head_of[NBKT];
	logic [63:0]   name_at[CAP];
	logic [31:0]   data_at[CAP];
	int unsigned   next_of[CAP];
	int unsigned   fill;

	op_t  pending[$];
	res_t expected[$];
	logic [63:0] known_names[$];
	int   errors = 0;
	bit   stim_done = 0;
	bit   in_fire = 0;
	longint cycles = 0;

	function automatic logic [63:0] trim_name(logic [63:0] raw);
		logic [63:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (raw[8*i +: 8] == 8'd0) break;
			n[8*i +: 8] = raw[8*i +: 8];
		end
		return n;
	endfunction

	function automatic int unsigned sdbm_bucket(logic [63:0] n);
		logic [63:0] h;
		h = '0;
		for (int i = 0; i < 8; i++) begin
			if (n[8*i +: 8] == 8'd0) break;
			h = {56'd0, n[8*i +: 8]} + (h << 6) + (h << 16) - h;
		end
		return int'(h % 64'd127);
	endfunction

	function automatic int unsigned chain_find(int unsigned b, logic [63:0] n);
		int unsigned p;
		p = head_of[b];
		while (p != 0) begin
			if (name_at[p-1] == n) return p;
			p = next_of[p-1];
		end
		return 0;
	endfunction

	function automatic res_t predict_dictionary(op_t op);
		logic [63:0] n;
		int unsigned b, hit;
		res_t r;
		n = trim_name(op.key);
		b = sdbm_bucket(n);
		r.status = ST_MISS;
		r.value_out = '0;
		hit = 0;
		if (op.kind == KIND_FIND) begin
			hit = chain_find(b, n);
			if (hit != 0) begin
				r.status = ST_OK;
				r.value_out = data_at[hit-1];
			end
		end else if (op.kind == KIND_ADD || op.kind == KIND_REPLACE) begin
			if (op.kind == KIND_ADD) hit = chain_find(b, n);
			if (hit != 0) r.status = ST_MISS;
			else if (fill >= CAP) r.status = ST_FULL;
			else begin
				name_at[fill] = n;
				data_at[fill] = op.value;
				next_of[fill] = head_of[b];
				fill++;
				head_of[b] = fill;
				r.status = ST_OK;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_name();
		logic [63:0] k;
		int len;
		len = $urandom_range(0, 8);
		k = {$urandom, $urandom};
		for (int i = 0; i < 8; i++)
			if (i < len && k[8*i +: 8] == 8'd0) k[8*i +: 8] = 8'h41;
		// junk after the terminator on half the keys shorter than eight bytes
		if (len < 8 && $urandom_range(0, 1)) k[8*len +: 8] = 8'd0;
		else if (len < 8) k = k & ((64'd1 << (8*len)) - 1);
		return k;
	endfunction

	function automatic op_t mk(logic [1:0] kd, logic [63:0] k, logic [31:0] v);
		op_t o;
		o.kind = kd; o.key = k; o.value = v;
		return o;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		logic [63:0] k;
		int r;
		foreach (head_of[i]) head_of[i] = 0;
		fill = 0;
		// directed: extremes, every kind, empty name, junk after end, kind 3
		pending.push_back(mk(KIND_FIND, 64'd0, 32'hFFFF_FFFF));
		pending.push_back(mk(KIND_ADD, 64'd0, 32'h1234_5678));
		pending.push_back(mk(KIND_FIND, 64'hFFFF_FFFF_FFFF_FF00, 32'd0));
		pending.push_back(mk(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
		pending.push_back(mk(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
		pending.push_back(mk(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5));
		pending.push_back(mk(KIND_ADD, 64'h0000_0000_0000_6261, 32'd1));
		pending.push_back(mk(KIND_FIND, 64'hDEAD_BE00_0000_6261, 32'd0));
		pending.push_back(mk(KIND_REPLACE, 64'hAAAA_0000_0000_6261, 32'd2));
		pending.push_back(mk(KIND_FIND, 64'h0000_0000_0000_6261, 32'd0));
		pending.push_back(mk(2'd3, 64'h0000_0000_0000_6261, 32'd9));
		pending.push_back(mk(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
		pending.push_back(mk(KIND_FIND, 64'h0000_0000_0000_7A7A, 32'd0));
		pending.push_back(mk(KIND_REPLACE, 64'd0, 32'hA5A5_A5A5));
		pending.push_back(mk(KIND_FIND, 64'h0100_0000_0000_0000, 32'd0));
		known_names.push_back(64'h6261);
		known_names.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		known_names.push_back(64'd0);
		// random: reuse names often so chains and shadows build, store fills up
		for (int i = 0; i < 1900; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55 && known_names.size() > 0)
				k = known_names[$urandom_range(0, known_names.size() - 1)];
			else begin
				k = rand_name();
				if (known_names.size() < 64) known_names.push_back(k);
			end
			r = $urandom_range(0, 99);
			pending.push_back(mk(r < 45 ? KIND_FIND : r < 75 ? KIND_ADD :
				r < 97 ? KIND_REPLACE : 2'd3, k, $urandom));
		end
	end

	// driver: bursts and gaps
	int gap_left = 0;
	int burst_left = 0;
	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			// in_fire marks a transfer at the last rising edge
			if (in_fire) pending.delete(0);
			if (!in_ch.valid || in_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending[0];
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 90);
					end
				end else begin
					in_ch.valid <= 1'b0;
					stim_done = 1;
				end
			end
			// receiver stall pattern: long open stretches, occasional long stalls
			case (cycles[11:10])
				2'd0: out_ch.ready <= 1'b1;
				2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ch.ready <= (cycles[6:4] != 3'd5);
				default: out_ch.ready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t got, want;
		cycles <= cycles + 1;
		in_fire = arst_n && in_ch.valid && in_ch.ready;
		if (in_fire) expected.push_back(predict_dictionary(in_ch.data));
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected.size() == 0) begin
				$display("%0t: unexpected transfer status=%0d value_out=%h",
					$time, got.status, got.value_out);
				errors++;
			end else begin
				want = expected.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					errors++;
				end
				if (got.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h actual %h",
						$time, want.value_out, got.value_out);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done && expected.size() == 0 && !in_ch.valid);
		repeat (700) @(posedge clk);
		if (errors == 0 && expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		wait (cycles >= LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

>>> sim.f
+incdir+sv
sv/chd_pkg.sv
sv/chd_stream_if.sv
sv/chained_hash_dictionary_core.sv
sv/chd_checker.sv
tb/sv/tb_top.sv
